/* sv/constraint_correction_field_kernel_macros.svh */
// Assertion macros shared by the checker of the correction field kernel
`ifndef CONSTRAINT_CORRECTION_FIELD_KERNEL_MACROS_SVH
`define CONSTRAINT_CORRECTION_FIELD_KERNEL_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define CCFK_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define CCFK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ccfk_pkg.sv */
// Types, constants and helpers shared by the correction field kernel
`timescale 1ns / 1ps
package ccfk_pkg;

   localparam int CCFK_MAX_CONSTRAINTS = 16;
   localparam int CCFK_TABLE_STEPS     = 1024;
   localparam int QUEUE_DEPTH          = 2;

   localparam int COORD_W  = 44;
   localparam int OFFSET_W = 45;
   localparam int CHUNK_W  = 15;
   localparam int CHUNKS   = 3;
   localparam int SUMSQ_W  = 92;
   localparam int ROOT_W   = 46;
   localparam int ACC_W    = 48;

   localparam logic [1:0] OP_LOAD_TABLE      = 2'd0;
   localparam logic [1:0] OP_LOAD_CONSTRAINT = 2'd1;
   localparam logic [1:0] OP_EVALUATE        = 2'd2;
   localparam logic [1:0] OP_RESERVED        = 2'd3;

   localparam logic [2:0] CSR_CELL_SIZE_X      = 3'd0;
   localparam logic [2:0] CSR_CELL_SIZE_Y      = 3'd1;
   localparam logic [2:0] CSR_CELL_SIZE_Z      = 3'd2;
   localparam logic [2:0] CSR_BOX_SIZE_X       = 3'd3;
   localparam logic [2:0] CSR_BOX_SIZE_Y       = 3'd4;
   localparam logic [2:0] CSR_BOX_SIZE_Z       = 3'd5;
   localparam logic [2:0] CSR_RADIAL_STEP      = 3'd6;
   localparam logic [2:0] CSR_CONSTRAINT_COUNT = 3'd7;

   localparam logic [31:0] RST_CELL_SIZE   = 32'd65536;
   localparam logic [31:0] RST_BOX_SIZE    = 32'd67108864;
   localparam logic [31:0] RST_RADIAL_STEP = 32'd65536;

   localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
   localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [10:0]        slot;
      logic signed [31:0] load_value;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
      logic [31:0]        pos_z;
      logic [11:0]        cell_x;
      logic [11:0]        cell_y;
      logic [11:0]        cell_z;
      logic signed [31:0] grid_value;
   } ccfk_req_type;

   typedef struct packed {
      logic signed [31:0] new_value;
      logic signed [31:0] correction;
   } ccfk_rsp_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [10:0]        slot;
      logic signed [31:0] load_value;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
      logic [31:0]        pos_z;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic signed [31:0] grid_value;
   } ccfk_item_type;

   typedef struct packed {
      logic          valid;
      ccfk_item_type item;
   } ccfk_qhead_type;

   typedef struct packed {
      logic [31:0] cell_size_x;
      logic [31:0] cell_size_y;
      logic [31:0] cell_size_z;
      logic [31:0] box_size_x;
      logic [31:0] box_size_y;
      logic [31:0] box_size_z;
      logic [31:0] radial_step;
      logic [4:0]  constraint_count;
   } ccfk_cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* sv/ccfk_front.sv */
// Front end: accepts transactions, drops reserved opcodes, forms cell coordinates
`timescale 1ns / 1ps
module ccfk_front import ccfk_pkg::*; (
   input  logic          req_valid,
   input  ccfk_req_type  req_data,
   output logic          req_stall,
   input  ccfk_cfg_type  cfg,
   input  logic          q_full,
   output logic          q_push,
   output ccfk_item_type q_item
);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full && (req_data.opcode != OP_RESERVED);

   always_comb begin
      q_item.opcode     = req_data.opcode;
      q_item.slot       = req_data.slot;
      q_item.load_value = req_data.load_value;
      q_item.pos_x      = req_data.pos_x;
      q_item.pos_y      = req_data.pos_y;
      q_item.pos_z      = req_data.pos_z;
      q_item.coord_x    = COORD_W'(req_data.cell_x) * COORD_W'(cfg.cell_size_x);
      q_item.coord_y    = COORD_W'(req_data.cell_y) * COORD_W'(cfg.cell_size_y);
      q_item.coord_z    = COORD_W'(req_data.cell_z) * COORD_W'(cfg.cell_size_z);
      q_item.grid_value = req_data.grid_value;
   end

endmodule

/* sv/ccfk_queue.sv */
// Short FIFO between the front end and the back end
`timescale 1ns / 1ps
module ccfk_queue import ccfk_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  ccfk_item_type  push_item,
   output logic           full,
   input  logic           pop,
   output ccfk_qhead_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   ccfk_item_type    entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/ccfk_back.sv */
// Back end: executes loads and runs the per-constraint correction sequencer
`timescale 1ns / 1ps
module ccfk_back import ccfk_pkg::*; #(
   parameter int MAX_CONSTRAINTS = CCFK_MAX_CONSTRAINTS,
   parameter int TABLE_STEPS     = CCFK_TABLE_STEPS
) (
   input  logic           clock,
   input  logic           reset,
   input  ccfk_cfg_type   cfg,
   input  ccfk_qhead_type head,
   output logic           pop,
   output logic           rsp_valid,
   output ccfk_rsp_type   rsp_data,
   input  logic           rsp_stall
);

   localparam int AW     = $clog2(TABLE_STEPS + 1);
   localparam int KW     = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
   localparam int NW     = $clog2(MAX_CONSTRAINTS + 1);
   localparam int RMAX_W = 32 + AW;
   localparam int DIV_W  = (ROOT_W > RMAX_W) ? ROOT_W : RMAX_W;
   localparam int MAG_W  = 33;
   localparam int QUO_W  = 33;
   localparam int PROD_W = 65;
   localparam int REM_W  = ROOT_W + 3;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CFETCH = 4'd1;
   localparam logic [3:0] S_AXIS   = 4'd2;
   localparam logic [3:0] S_SQ     = 4'd3;
   localparam logic [3:0] S_SQRT   = 4'd4;
   localparam logic [3:0] S_RANGE  = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_TPREV  = 4'd7;
   localparam logic [3:0] S_TNEXT  = 4'd8;
   localparam logic [3:0] S_TPROD  = 4'd9;
   localparam logic [3:0] S_QDIV   = 4'd10;
   localparam logic [3:0] S_VAL    = 4'd11;
   localparam logic [3:0] S_MUL    = 4'd12;
   localparam logic [3:0] S_ACC    = 4'd13;
   localparam logic [3:0] S_DONE   = 4'd14;

   typedef struct packed {
      logic signed [31:0] weight;
      logic [31:0]        pos_x;
      logic [31:0]        pos_y;
      logic [31:0]        pos_z;
   } ccfk_cst_type;

   logic signed [31:0] tbl_mem [0:TABLE_STEPS];
   ccfk_cst_type       cst_mem [0:MAX_CONSTRAINTS-1];

   logic signed [31:0] tbl_rd_ff;
   ccfk_cst_type       cst_rd_ff;
   logic               tbl_we, cst_we;
   logic [AW-1:0]      tbl_addr;

   logic [3:0]          state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [1:0]          axis_ff, axis_in;
   logic [NW-1:0]       k_ff, k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ccfk_rsp_type        rsp_data_ff, rsp_data_in;

   ccfk_item_type       cur_ff, cur_in;
   logic [OFFSET_W-1:0] d_ff, d_in;
   logic [SUMSQ_W-1:0]  sum_ff, sum_in;
   logic [SUMSQ_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [31:0]         frac_ff, frac_in;
   logic signed [31:0]  prev_ff, prev_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic signed [31:0]  val_ff, val_in;
   logic signed [63:0]  term_ff, term_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [RMAX_W-1:0]   rmax_ff, rmax_in;

   logic [31:0]         step_eff;
   logic [NW-1:0]       n_eff;
   logic                rsp_free;

   logic [COORD_W-1:0]  ax_coord;
   logic [31:0]         ax_pos, ax_box;
   logic signed [47:0]  dx, twice, boxs, dxw;
   logic [47:0]         dmag;
   logic [CHUNK_W-1:0]  chunk;
   logic [OFFSET_W+CHUNK_W-1:0] partial;
   logic [REM_W-1:0]    rem_try, trial;
   logic                sq_ge;
   logic [DIV_W-1:0]    div_shift;
   logic [PROD_W-1:0]   quo_shift;
   logic signed [32:0]  diff;
   logic [MAG_W-1:0]    mag;
   logic signed [33:0]  val_wide;
   logic signed [48:0]  total;
   int                  bidx;

   assign step_eff  = (cfg.radial_step == '0) ? 32'd1 : cfg.radial_step;
   assign rmax_in   = RMAX_W'(step_eff) * RMAX_W'(TABLE_STEPS);
   assign n_eff     = (32'(cfg.constraint_count) > MAX_CONSTRAINTS) ?
                      NW'(MAX_CONSTRAINTS) : NW'(cfg.constraint_count);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_IDLE) && head.valid;
   assign tbl_we    = pop && (head.item.opcode == OP_LOAD_TABLE) &&
                      (32'(head.item.slot) <= TABLE_STEPS);
   assign cst_we    = pop && (head.item.opcode == OP_LOAD_CONSTRAINT) &&
                      (32'(head.item.slot) < MAX_CONSTRAINTS);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            ax_coord = cur_ff.coord_x;
            ax_pos   = cst_rd_ff.pos_x;
            ax_box   = cfg.box_size_x;
         end
         2'd1: begin
            ax_coord = cur_ff.coord_y;
            ax_pos   = cst_rd_ff.pos_y;
            ax_box   = cfg.box_size_y;
         end
         default: begin
            ax_coord = cur_ff.coord_z;
            ax_pos   = cst_rd_ff.pos_z;
            ax_box   = cfg.box_size_z;
         end
      endcase
      dx    = $signed({4'b0, ax_coord}) - $signed({16'b0, ax_pos});
      twice = dx <<< 1;
      boxs  = $signed({16'b0, ax_box});
      if (twice > boxs) begin
         dxw = dx - boxs;
      end else if (twice < -boxs) begin
         dxw = dx + boxs;
      end else begin
         dxw = dx;
      end
      dmag = dxw[47] ? 48'(-dxw) : 48'(dxw);
   end

   always_comb begin
      chunk    = d_ff[cnt_ff[1:0]*CHUNK_W +: CHUNK_W];
      partial  = d_ff * chunk;
      rem_try  = {rem_ff[REM_W-3:0], rad_ff[SUMSQ_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      sq_ge    = (rem_try >= trial);
      div_shift = DIV_W'(step_eff) << (AW - 1 - int'(cnt_ff));
      quo_shift = PROD_W'(step_eff) << (QUO_W - 1 - int'(cnt_ff));
      diff     = $signed({tbl_rd_ff[31], tbl_rd_ff}) - $signed({prev_ff[31], prev_ff});
      mag      = diff[32] ? MAG_W'(-diff) : MAG_W'(diff);
      val_wide = neg_ff ? ($signed({{2{prev_ff[31]}}, prev_ff}) - $signed({1'b0, quo_ff}))
                        : ($signed({{2{prev_ff[31]}}, prev_ff}) + $signed({1'b0, quo_ff}));
      total    = 49'($signed(cur_ff.grid_value)) + 49'(acc_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cur_in       = cur_ff;
      d_in         = d_ff;
      sum_in       = sum_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      div_in       = div_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      prev_in      = prev_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      val_in       = val_ff;
      term_in      = term_ff;
      acc_in       = acc_ff;
      tbl_addr     = idx_ff;
      bidx         = 0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (head.valid && (head.item.opcode == OP_EVALUATE)) begin
               cur_in = head.item;
               acc_in = '0;
               k_in   = '0;
               state_in = (n_eff == '0) ? S_DONE : S_CFETCH;
            end
         end
         S_CFETCH: begin
            axis_in  = 2'd0;
            sum_in   = '0;
            state_in = S_AXIS;
         end
         S_AXIS: begin
            d_in     = dmag[OFFSET_W-1:0];
            cnt_in   = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            sum_in = sum_ff + (SUMSQ_W'(partial) << (int'(cnt_ff[1:0]) * CHUNK_W));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(CHUNKS - 1)) begin
               if (axis_ff == 2'd2) begin
                  rad_in   = sum_in;
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = '0;
                  state_in = S_SQRT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_AXIS;
               end
            end
         end
         S_SQRT: begin
            rem_in  = sq_ge ? (rem_try - trial) : rem_try;
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            rad_in  = rad_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'(ROOT_W - 1)) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (DIV_W'(root_ff) > DIV_W'(rmax_ff)) begin
               val_in   = '0;
               state_in = S_MUL;
            end else if (DIV_W'(root_ff) == DIV_W'(rmax_ff)) begin
               idx_in   = AW'(TABLE_STEPS);
               frac_in  = '0;
               state_in = S_TPREV;
            end else begin
               div_in   = DIV_W'(root_ff);
               idx_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            bidx = AW - 1 - int'(cnt_ff);
            if (div_ff >= div_shift) begin
               div_in       = div_ff - div_shift;
               idx_in[bidx] = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(AW - 1)) begin
               frac_in  = div_in[31:0];
               state_in = S_TPREV;
            end
         end
         S_TPREV: begin
            tbl_addr = idx_ff;
            state_in = S_TNEXT;
         end
         S_TNEXT: begin
            tbl_addr = (idx_ff == AW'(TABLE_STEPS)) ? idx_ff : AW'(idx_ff + 1'b1);
            prev_in  = tbl_rd_ff;
            state_in = S_TPROD;
         end
         S_TPROD: begin
            prod_in  = mag * frac_ff;
            neg_in   = diff[32];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_QDIV;
         end
         S_QDIV: begin
            bidx = QUO_W - 1 - int'(cnt_ff);
            if (prod_ff >= quo_shift) begin
               prod_in      = prod_ff - quo_shift;
               quo_in[bidx] = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(QUO_W - 1)) begin
               state_in = S_VAL;
            end
         end
         S_VAL: begin
            val_in   = val_wide[31:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            term_in  = $signed(cst_rd_ff.weight) * val_ff;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff + ACC_W'(term_ff >>> 24);
            if (NW'(k_ff + 1'b1) == n_eff) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_CFETCH;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.new_value  = sat32(total);
               rsp_data_in.correction = sat32(49'(acc_ff));
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      axis_ff     <= axis_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      cur_ff      <= cur_in;
      d_ff        <= d_in;
      sum_ff      <= sum_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      div_ff      <= div_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      prev_ff     <= prev_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      quo_ff      <= quo_in;
      val_ff      <= val_in;
      term_ff     <= term_in;
      acc_ff      <= acc_in;
      rmax_ff     <= rmax_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[AW'(head.item.slot)] <= head.item.load_value;
      end
      tbl_rd_ff <= tbl_mem[tbl_addr];
   end

   always_ff @(posedge clock) begin
      if (cst_we) begin
         cst_mem[KW'(head.item.slot)] <= '{weight: head.item.load_value,
                                           pos_x:  head.item.pos_x,
                                           pos_y:  head.item.pos_y,
                                           pos_z:  head.item.pos_z};
      end
      cst_rd_ff <= cst_mem[KW'(k_ff)];
   end

endmodule

/* sv/constraint_correction_field_kernel.sv */
// Correction field kernel: one evaluate transaction gives one result, loads give none.
// Loads are written from the queue head as they are popped; they need no clearing after reset.
// Each evaluate runs the used constraints one after another through a 46-step square root, the
// 33-step interpolation divide and the index divide, all in one shared sequencer.
// Reset is synchronous and active high: clears queue, sequencer, output valid and configuration registers.
`timescale 1ns / 1ps
module constraint_correction_field_kernel import ccfk_pkg::*; #(
   parameter int MAX_CONSTRAINTS = CCFK_MAX_CONSTRAINTS,
   parameter int TABLE_STEPS     = CCFK_TABLE_STEPS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  ccfk_req_type req_data,
   output logic         req_stall,
   output logic         rsp_valid,
   output ccfk_rsp_type rsp_data,
   input  logic         rsp_stall,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   ccfk_cfg_type   cfg_ff, cfg_in;
   logic           q_full, q_push, q_pop;
   ccfk_item_type  q_item;
   ccfk_qhead_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CELL_SIZE_X:      cfg_in.cell_size_x      = csr_wdata;
            CSR_CELL_SIZE_Y:      cfg_in.cell_size_y      = csr_wdata;
            CSR_CELL_SIZE_Z:      cfg_in.cell_size_z      = csr_wdata;
            CSR_BOX_SIZE_X:       cfg_in.box_size_x       = csr_wdata;
            CSR_BOX_SIZE_Y:       cfg_in.box_size_y       = csr_wdata;
            CSR_BOX_SIZE_Z:       cfg_in.box_size_z       = csr_wdata;
            CSR_RADIAL_STEP:      cfg_in.radial_step      = csr_wdata;
            CSR_CONSTRAINT_COUNT: cfg_in.constraint_count = csr_wdata[4:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_size_x      <= RST_CELL_SIZE;
         cfg_ff.cell_size_y      <= RST_CELL_SIZE;
         cfg_ff.cell_size_z      <= RST_CELL_SIZE;
         cfg_ff.box_size_x       <= RST_BOX_SIZE;
         cfg_ff.box_size_y       <= RST_BOX_SIZE;
         cfg_ff.box_size_z       <= RST_BOX_SIZE;
         cfg_ff.radial_step      <= RST_RADIAL_STEP;
         cfg_ff.constraint_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccfk_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (q_item)
   );

   ccfk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head)
   );

   ccfk_back #(
      .MAX_CONSTRAINTS (MAX_CONSTRAINTS),
      .TABLE_STEPS     (TABLE_STEPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

/* sv/ccfk_checker.sv */
// Port-level checker for the correction field kernel and its bind
`timescale 1ns / 1ps
`include "constraint_correction_field_kernel_macros.svh"
module ccfk_checker import ccfk_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input ccfk_rsp_type rsp_data,
   input logic         rsp_stall
);

   `CCFK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result transaction changed or dropped")
   `CCFK_ASSERT_IMPLY(a_stall_after_accept, clock, reset, $rose(req_stall), $past(req_valid && !req_stall), "request stall rose without an accepted transaction")
   `CCFK_ASSERT_IMPLY(a_clean_after_reset, clock, reset, $past(reset), !req_stall && !rsp_valid, "kernel not empty after reset")

endmodule

bind constraint_correction_field_kernel ccfk_checker u_checker (.*);
